// File: design/rpa_pkg.sv
`timescale 1ns / 1ps

package rpa_pkg;

   // field and register widths
   localparam int PixW    = 8;
   localparam int ModeW   = 3;
   localparam int AmountW = 6;
   localparam int CsrIdxW = 1;
   localparam int CsrDatW = 6;

   // mode register codes
   localparam logic [ModeW-1:0] ModeAddRed   = 3'd0;
   localparam logic [ModeW-1:0] ModeAddGreen = 3'd1;
   localparam logic [ModeW-1:0] ModeAddBlue  = 3'd2;
   localparam logic [ModeW-1:0] ModeBright   = 3'd3;
   localparam logic [ModeW-1:0] ModeContrast = 3'd4;
   localparam logic [ModeW-1:0] ModeGray     = 3'd5;

   // register indexes on the csr port
   localparam logic [CsrIdxW-1:0] CsrMode   = 1'b0;
   localparam logic [CsrIdxW-1:0] CsrAmount = 1'b1;

   // contrast: offset that keeps the scaled product non-negative before /255
   localparam int          ContrastBiasQ = 144;
   localparam logic [18:0] ContrastBias  = 19'(ContrastBiasQ * 255);

   // clamp a signed value to 0..255
   function automatic logic [PixW-1:0] sat8(logic signed [10:0] v);
      logic [PixW-1:0] r;
      if (v < 11'sd0) begin
         r = 8'd0;
      end else if (v > 11'sd255) begin
         r = 8'd255;
      end else begin
         r = v[PixW-1:0];
      end
      return r;
   endfunction

   // channel plus signed amount, saturated
   function automatic logic [PixW-1:0] add_sat(logic [PixW-1:0] c,
                                              logic signed [AmountW-1:0] amt);
      logic signed [10:0] v;
      v = $signed({3'b000, c}) + 11'(amt);
      return sat8(v);
   endfunction

   // 128 + floor((amt+255)*(c-128)/255), saturated
   // the division uses x*257>>16 as an estimate, then one correction step
   function automatic logic [PixW-1:0] contrast_ch(logic [PixW-1:0] c,
                                                  logic signed [AmountW-1:0] amt);
      logic signed [9:0]  fac;
      logic signed [8:0]  dif;
      logic signed [18:0] num;
      logic [17:0]        pos;
      logic [25:0]        est;
      logic [9:0]         q0;
      logic [17:0]        rem;
      logic [9:0]         q;
      logic signed [10:0] v;
      fac = 10'sd255 + 10'(amt);
      dif = $signed({1'b0, c}) - 9'sd128;
      num = 19'(fac) * 19'(dif);
      pos = 18'(num + $signed(ContrastBias));
      est = {8'b0, pos} + {pos, 8'b0};
      q0  = est[25:16];
      rem = pos - ({q0, 8'b0} - 18'(q0));
      q   = (rem >= 18'd255) ? q0 + 10'd1 : q0;
      v   = 11'sd128 + $signed({1'b0, q}) - 11'(ContrastBiasQ);
      return sat8(v);
   endfunction

   // floor((r+g+b)/3) by reciprocal 683/2048, exact for sums up to 765
   function automatic logic [PixW-1:0] gray3(logic [PixW-1:0] r, logic [PixW-1:0] g,
                                            logic [PixW-1:0] b);
      logic [9:0]  sum;
      logic [19:0] prod;
      sum  = {2'b00, r} + {2'b00, g} + {2'b00, b};
      prod = 20'(sum) * 20'd683;
      return prod[18:11];
   endfunction

endpackage

// File: design/rgb_pixel_adjust.sv
`timescale 1ns / 1ps

// rgb_pixel_adjust: per-pixel brightness, contrast and grayscale adjust.
// req channel: one pixel per beat (req_in_red/green/blue), valid/ready.
// rsp channel: one adjusted pixel per beat (rsp_out_red/green/blue).
// csr channel: register writes, csr_index 0 = mode, 1 = amount; always ready.
//   write registers only while no pixel is in flight.
// path: an accepted pixel goes to the input register, then to the result
//   register, which drives rsp; it moves on when rsp is empty or ready.
// throughput: one pixel per clock while rsp_ready is high; the input and the
//   result register form a two-stage pipeline, all math sits between them.
// stall: when rsp_ready is low the result holds; one more pixel can sit in
//   the input register, after that req_ready drops.
// reset (synchronous, active high): both stages empty, mode = 0, amount = 0.
module rgb_pixel_adjust (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [rpa_pkg::PixW-1:0]      req_in_red,
   input  logic [rpa_pkg::PixW-1:0]      req_in_green,
   input  logic [rpa_pkg::PixW-1:0]      req_in_blue,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rpa_pkg::PixW-1:0]      rsp_out_red,
   output logic [rpa_pkg::PixW-1:0]      rsp_out_green,
   output logic [rpa_pkg::PixW-1:0]      rsp_out_blue,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rpa_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [rpa_pkg::CsrDatW-1:0]   csr_data
);
   import rpa_pkg::*;

   logic [ModeW-1:0]          mode_ff;
   logic signed [AmountW-1:0] amount_ff;

   logic            s1_valid_ff, s1_valid_in;
   logic [PixW-1:0] s1_red_ff, s1_green_ff, s1_blue_ff;
   logic            s2_valid_ff, s2_valid_in;
   logic [PixW-1:0] s2_red_ff, s2_green_ff, s2_blue_ff;
   logic [PixW-1:0] s2_red_in, s2_green_in, s2_blue_in;

   logic req_beat, s1_move;

   // config registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= ModeAddRed;
         amount_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CsrMode:   mode_ff   <= csr_data[ModeW-1:0];
            CsrAmount: amount_ff <= $signed(csr_data[AmountW-1:0]);
            default:   ;
         endcase
      end
   end

   // pipeline flow control
   assign s1_move     = s1_valid_ff && (!s2_valid_ff || rsp_ready);
   assign req_ready   = !s1_valid_ff || s1_move;
   assign req_beat    = req_valid && req_ready;
   assign s1_valid_in = req_beat || (s1_valid_ff && !s1_move);
   assign s2_valid_in = s1_move || (s2_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (req_beat) begin
         s1_red_ff   <= req_in_red;
         s1_green_ff <= req_in_green;
         s1_blue_ff  <= req_in_blue;
      end
   end

   // point operation on the registered pixel
   always_comb begin
      s2_red_in   = s1_red_ff;
      s2_green_in = s1_green_ff;
      s2_blue_in  = s1_blue_ff;
      unique case (mode_ff)
         ModeAddRed:   s2_red_in   = add_sat(s1_red_ff, amount_ff);
         ModeAddGreen: s2_green_in = add_sat(s1_green_ff, amount_ff);
         ModeAddBlue:  s2_blue_in  = add_sat(s1_blue_ff, amount_ff);
         ModeBright: begin
            s2_red_in   = add_sat(s1_red_ff, amount_ff);
            s2_green_in = add_sat(s1_green_ff, amount_ff);
            s2_blue_in  = add_sat(s1_blue_ff, amount_ff);
         end
         ModeContrast: begin
            s2_red_in   = contrast_ch(s1_red_ff, amount_ff);
            s2_green_in = contrast_ch(s1_green_ff, amount_ff);
            s2_blue_in  = contrast_ch(s1_blue_ff, amount_ff);
         end
         ModeGray: begin
            s2_red_in   = gray3(s1_red_ff, s1_green_ff, s1_blue_ff);
            s2_green_in = s2_red_in;
            s2_blue_in  = s2_red_in;
         end
         // unused modes pass the pixel through
         default: ;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_red_ff   <= s2_red_in;
         s2_green_ff <= s2_green_in;
         s2_blue_ff  <= s2_blue_in;
      end
   end

   assign rsp_valid     = s2_valid_ff;
   assign rsp_out_red   = s2_red_ff;
   assign rsp_out_green = s2_green_ff;
   assign rsp_out_blue  = s2_blue_ff;

endmodule

// File: design/rpa_checker.sv
`timescale 1ns / 1ps

module rpa_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [rpa_pkg::PixW-1:0] rsp_out_red,
   input logic [rpa_pkg::PixW-1:0] rsp_out_green,
   input logic [rpa_pkg::PixW-1:0] rsp_out_blue
);
   import rpa_pkg::*;

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_red)
         && $stable(rsp_out_green) && $stable(rsp_out_blue))
      else $error("stalled rsp beat changed");

   // an empty output stage never blocks the input
   a_no_block: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req_ready low with empty output");

   // an accepted pixel reaches the output when rsp_ready is high while it sits in the input register
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) ##1 rsp_ready |=> rsp_valid)
      else $error("accepted pixel did not appear on rsp");

endmodule

bind rgb_pixel_adjust rpa_checker u_rpa_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_out_red   (rsp_out_red),
   .rsp_out_green (rsp_out_green),
   .rsp_out_blue  (rsp_out_blue)
);

// File: sim/pixel_adjust_checker.sv
`timescale 1ns / 1ps

module pixel_adjust_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [rpa_pkg::PixW-1:0]      req_in_red,
   input  logic [rpa_pkg::PixW-1:0]      req_in_green,
   input  logic [rpa_pkg::PixW-1:0]      req_in_blue,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [rpa_pkg::PixW-1:0]      rsp_out_red,
   input  logic [rpa_pkg::PixW-1:0]      rsp_out_green,
   input  logic [rpa_pkg::PixW-1:0]      rsp_out_blue,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [rpa_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [rpa_pkg::CsrDatW-1:0]   csr_data,
   output int                            fail_count,
   output int                            pending
);
   import rpa_pkg::*;

   typedef struct packed {
      logic [PixW-1:0] red;
      logic [PixW-1:0] green;
      logic [PixW-1:0] blue;
   } pixel_type;

   // shadow copy of the register file
   logic [ModeW-1:0]          cur_mode;
   logic signed [AmountW-1:0] cur_amount;

   // adjusted pixels still owed by the block, oldest first
   pixel_type expected_pixels[$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   // clamp to the 8-bit channel range
   function automatic logic [PixW-1:0] clamp_channel(int v);
      if (v < 0) begin
         return '0;
      end
      if (v > 255) begin
         return 8'd255;
      end
      return 8'(v);
   endfunction

   // contrast around mid gray, rounded toward minus infinity
   function automatic logic [PixW-1:0] stretch_channel(logic [PixW-1:0] c, int amt);
      int prod;
      int quo;
      prod = (amt + 255) * (int'(c) - 128);
      quo  = prod / 255;
      if (prod < 0 && (prod % 255) != 0) begin
         quo = quo - 1;
      end
      return clamp_channel(128 + quo);
   endfunction

   // full point operation for one pixel under the current registers
   function automatic pixel_type adjust_pixel(pixel_type p, logic [ModeW-1:0] mode,
                                              logic signed [AmountW-1:0] amt);
      int        a;
      int        r;
      int        g;
      int        b;
      int        gray;
      pixel_type q;
      a = amt;
      r = p.red;
      g = p.green;
      b = p.blue;
      q = p;
      case (mode)
         ModeAddRed: begin
            q.red = clamp_channel(r + a);
         end
         ModeAddGreen: begin
            q.green = clamp_channel(g + a);
         end
         ModeAddBlue: begin
            q.blue = clamp_channel(b + a);
         end
         ModeBright: begin
            q.red   = clamp_channel(r + a);
            q.green = clamp_channel(g + a);
            q.blue  = clamp_channel(b + a);
         end
         ModeContrast: begin
            q.red   = stretch_channel(p.red, a);
            q.green = stretch_channel(p.green, a);
            q.blue  = stretch_channel(p.blue, a);
         end
         ModeGray: begin
            gray    = (r + g + b) / 3;
            q.red   = 8'(gray);
            q.green = 8'(gray);
            q.blue  = 8'(gray);
         end
         default: begin
            // spare mode codes leave the pixel as it is
         end
      endcase
      return q;
   endfunction

   // one channel compare, only the first few misses are printed
   task automatic check_channel(string chan, logic [PixW-1:0] want, logic [PixW-1:0] got);
      if (want !== got) begin
         if (fail_count < 10) begin
            $display("%0t: %s mismatch, expected %0d got %0d", $realtime, chan, want, got);
         end
         fail_count = fail_count + 1;
      end
   endtask

   always @(posedge clock) begin
      pixel_type got;
      pixel_type want;
      if (reset) begin
         cur_mode   = ModeAddRed;
         cur_amount = '0;
         expected_pixels.delete();
      end else begin
         // register write beat
         if (csr_valid && csr_ready) begin
            if (csr_index == CsrMode) begin
               cur_mode = csr_data[ModeW-1:0];
            end else if (csr_index == CsrAmount) begin
               cur_amount = csr_data[AmountW-1:0];
            end
         end
         // pixel beat in
         if (req_valid && req_ready) begin
            expected_pixels.push_back(adjust_pixel({req_in_red, req_in_green, req_in_blue},
                                                   cur_mode, cur_amount));
         end
         // result beat out
         if (rsp_valid && rsp_ready) begin
            got = {rsp_out_red, rsp_out_green, rsp_out_blue};
            if (expected_pixels.size() == 0) begin
               if (fail_count < 10) begin
                  $display("%0t: unexpected result beat %0d %0d %0d", $realtime,
                           got.red, got.green, got.blue);
               end
               fail_count = fail_count + 1;
            end else begin
               want = expected_pixels.pop_front();
               check_channel("red", want.red, got.red);
               check_channel("green", want.green, got.green);
               check_channel("blue", want.blue, got.blue);
            end
         end
      end
      pending = expected_pixels.size();
   end

endmodule

// File: sim/rgb_pixel_adjust_test.sv
`timescale 1ns / 1ps

module rgb_pixel_adjust_test;
   import rpa_pkg::*;

   // spare mode codes, the block passes pixels through
   localparam logic [ModeW-1:0] ModeSpareLo = 3'd6;
   localparam logic [ModeW-1:0] ModeSpareHi = 3'd7;

   localparam int Segments   = 35;
   localparam int SegPixels  = 50;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [PixW-1:0]      req_in_red = '0;
   logic [PixW-1:0]      req_in_green = '0;
   logic [PixW-1:0]      req_in_blue = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [PixW-1:0]      rsp_out_red;
   logic [PixW-1:0]      rsp_out_green;
   logic [PixW-1:0]      rsp_out_blue;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CsrIdxW-1:0]   csr_index = '0;
   logic [CsrDatW-1:0]   csr_data = '0;

   int fail_count;
   int pending;

   // idle odds in percent for the sender and the receiver
   int send_gap_pct = 0;
   int stall_pct    = 0;

   always #10 clock = ~clock;

   rgb_pixel_adjust u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_in_red    (req_in_red),
      .req_in_green  (req_in_green),
      .req_in_blue   (req_in_blue),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   pixel_adjust_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_in_red    (req_in_red),
      .req_in_green  (req_in_green),
      .req_in_blue   (req_in_blue),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending       (pending)
   );

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // one pixel beat, with random gaps ahead of it
   task automatic send_pixel(input logic [PixW-1:0] r, input logic [PixW-1:0] g,
                             input logic [PixW-1:0] b);
      @(negedge clock);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid    <= 1'b0;
         req_in_red   <= PixW'($urandom);
         req_in_green <= PixW'($urandom);
         req_in_blue  <= PixW'($urandom);
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_in_red   <= r;
      req_in_green <= g;
      req_in_blue  <= b;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
   endtask

   // one register write beat, valid is lowered by the caller
   task automatic write_reg(input logic [CsrIdxW-1:0] idx, input logic [CsrDatW-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
   endtask

   // drain the pipeline, then load mode and amount
   task automatic program_regs(input logic [ModeW-1:0] mode,
                               input logic signed [AmountW-1:0] amt);
      logic [CsrDatW-1:0] mode_word;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) begin
         @(negedge clock);
      end
      repeat (3) @(negedge clock);
      // unused upper bits of the mode word carry noise
      mode_word = CsrDatW'($urandom);
      mode_word[ModeW-1:0] = mode;
      write_reg(CsrMode, mode_word);
      write_reg(CsrAmount, amt);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // mostly uniform, sometimes a range corner
   function automatic logic [PixW-1:0] random_channel();
      logic [PixW-1:0] v;
      v = PixW'($urandom);
      if ($urandom_range(7) == 0) begin
         case ($urandom_range(5))
            0: v = 8'd0;
            1: v = 8'd255;
            2: v = 8'd127;
            3: v = 8'd128;
            4: v = 8'd1;
            default: v = 8'd254;
         endcase
      end
      return v;
   endfunction

   function automatic logic signed [AmountW-1:0] random_amount();
      logic signed [AmountW-1:0] a;
      a = AmountW'($urandom);
      if ($urandom_range(3) == 0) begin
         case ($urandom_range(5))
            0: a = -6'sd32;
            1: a = 6'sd31;
            2: a = -6'sd31;
            3: a = 6'sd30;
            4: a = -6'sd30;
            default: a = '0;
         endcase
      end
      return a;
   endfunction

   function automatic logic [ModeW-1:0] random_mode();
      logic [ModeW-1:0] m;
      if ($urandom_range(9) < 8) begin
         m = ModeW'($urandom_range(5));
      end else if ($urandom_range(1) == 0) begin
         m = ModeSpareLo;
      end else begin
         m = ModeSpareHi;
      end
      return m;
   endfunction

   // reset
   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // stimulus and verdict
   initial begin
      int guard;
      int seg;
      int k;
      @(negedge reset);

      // directed: each mode, amount corners, channel corners
      program_regs(ModeAddRed, 6'sd31);
      send_pixel(8'd250, 8'd10, 8'd10);
      send_pixel(8'd0, 8'd0, 8'd0);
      program_regs(ModeAddGreen, -6'sd32);
      send_pixel(8'd10, 8'd20, 8'd30);
      send_pixel(8'd255, 8'd255, 8'd255);
      program_regs(ModeAddBlue, -6'sd30);
      send_pixel(8'd1, 8'd2, 8'd20);
      send_pixel(8'd0, 8'd0, 8'd255);
      program_regs(ModeBright, 6'sd30);
      send_pixel(8'd0, 8'd128, 8'd240);
      send_pixel(8'd255, 8'd255, 8'd255);
      program_regs(ModeBright, -6'sd31);
      send_pixel(8'd0, 8'd30, 8'd31);
      // contrast: strongest factor drives dark channels below zero
      program_regs(ModeContrast, 6'sd31);
      send_pixel(8'd0, 8'd255, 8'd128);
      send_pixel(8'd127, 8'd129, 8'd1);
      program_regs(ModeContrast, -6'sd32);
      send_pixel(8'd0, 8'd255, 8'd128);
      send_pixel(8'd64, 8'd200, 8'd100);
      program_regs(ModeContrast, '0);
      send_pixel(8'd0, 8'd255, 8'd37);
      program_regs(ModeGray, 6'sd5);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd0, 8'd0, 8'd1);
      send_pixel(8'd255, 8'd255, 8'd254);
      send_pixel(8'd1, 8'd1, 8'd0);
      program_regs(ModeSpareLo, 6'sd17);
      send_pixel(8'd1, 8'd2, 8'd3);
      program_regs(ModeSpareHi, -6'sd1);
      send_pixel(8'd255, 8'd0, 8'd170);

      // random: a new register setting per segment, idle pattern rotates
      for (seg = 0; seg < Segments; seg++) begin
         program_regs(random_mode(), random_amount());
         case (seg % 4)
            0: begin
               send_gap_pct = 0;
               stall_pct    = 0;
            end
            1: begin
               send_gap_pct = 65;
               stall_pct    = 0;
            end
            2: begin
               send_gap_pct = 0;
               stall_pct    = 65;
            end
            default: begin
               send_gap_pct = 24;
               stall_pct    = 24;
            end
         endcase
         for (k = 0; k < SegPixels; k++) begin
            send_pixel(random_channel(), random_channel(), random_channel());
         end
      end

      // let the last results drain
      @(negedge clock);
      req_valid <= 1'b0;
      guard = 0;
      while (pending != 0 && guard < 5000) begin
         @(negedge clock);
         guard++;
      end
      repeat (4) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // watchdog
   initial begin
      #4_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
